/* src/psts_pkg.sv */
package psts_pkg;

  // default table size
  localparam int unsigned TASK_SLOTS_DEF = 16;

  // item field widths
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned SLOT_FW  = 4;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_REGISTER = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ACTIVATE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_KILL     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PICK     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_REPORT   = 3'd4;

  // slot status codes
  localparam logic [STATUS_W-1:0] ST_DEAD  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SLEEP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WAIT  = 2'd2;

  // one row of the task table
  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [STATUS_W-1:0] status;
    logic                active;
    logic [WORD_W-1:0]   resume;
    logic [WORD_W-1:0]   order;
  } slot_entry_t;

endpackage

/* src/psts_in_if.sv */
interface psts_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [psts_pkg::ACTION_W-1:0]          action;
  logic [psts_pkg::SLOT_FW-1:0]           task_slot;
  logic [psts_pkg::PRIO_W-1:0]            priority_req;
  logic signed [psts_pkg::WORD_W-1:0]     delay_or_return;
  logic [psts_pkg::WORD_W-1:0]            now_tick;

  modport source (
    output valid, action, task_slot, priority_req, delay_or_return, now_tick,
    input  ready
  );
  modport sink (
    input  valid, action, task_slot, priority_req, delay_or_return, now_tick,
    output ready
  );
endinterface

/* src/psts_out_if.sv */
interface psts_out_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [psts_pkg::SLOT_FW-1:0]    result_slot;
  logic [psts_pkg::STATUS_W-1:0]   result_status;
  logic [psts_pkg::WORD_W-1:0]     result_order;

  modport source (
    output valid, found, result_slot, result_status, result_order,
    input  ready
  );
  modport sink (
    input  valid, found, result_slot, result_status, result_order,
    output ready
  );
endinterface

/* src/priority_sleep_task_scheduler.sv */
// Cooperative priority task scheduler over a table of TASK_SLOTS task slots,
// one result item per input item. Register, activate, kill and report read
// the addressed slot on acceptance, then update it, write it back and load
// the result register. Pick walks the table with a single shared compare
// unit, one slot per cycle over the one read port of the slot memory, then
// loads the winner into the result register. The block takes one item at a
// time; input ready is high only while idle, and a finished result may wait
// in the output register while the next item is accepted. A finished item
// waits in its last step if the previous result has not been taken yet. Pick
// chooses the lowest priority among active sleeping slots whose resume tick
// is at or below now_tick (plain unsigned compare); equal priorities go to
// the larger order number, then to the lower slot. The user must write the
// wait-for-resume return code through cfg_we_i / cfg_wdata_i only while the
// block is idle; the block does not enforce this. The code resets to -1.
module priority_sleep_task_scheduler #(
  parameter int unsigned TASK_SLOTS = psts_pkg::TASK_SLOTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic signed [psts_pkg::WORD_W-1:0] cfg_wdata_i,
  psts_in_if.sink                            in_i,
  psts_out_if.source                         out_o
);

  localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0; // waiting for an item
  localparam logic [2:0] S_OP   = 3'd1; // update one slot, emit result
  localparam logic [2:0] S_SCAN = 3'd2; // walk the table, one slot per cycle
  localparam logic [2:0] S_LAST = 3'd3; // compare the last slot read
  localparam logic [2:0] S_DONE = 3'd4; // emit the pick result

  logic [2:0] state_q, state_d;

  // config register
  logic signed [psts_pkg::WORD_W-1:0] wait_code_q;

  // latched item
  logic [psts_pkg::ACTION_W-1:0] act_q;
  logic [psts_pkg::SLOT_FW-1:0]  slot_q;
  logic [psts_pkg::PRIO_W-1:0]   prio_q;
  logic [psts_pkg::WORD_W-1:0]   arg_q;
  logic [psts_pkg::WORD_W-1:0]   now_q;
  logic                          oor_q;

  // insertion counter
  logic [psts_pkg::WORD_W-1:0] cnt_q;

  // slot memory with per-slot valid bits; an unwritten slot reads as reset
  psts_pkg::slot_entry_t mem_q [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] vld_q;
  psts_pkg::slot_entry_t rd_data_q;
  logic                  rd_hit_q;
  logic [SLOT_W-1:0]     rd_idx_q;
  logic                  rd_en;
  logic [SLOT_W-1:0]     rd_addr;
  logic                  wr_en;
  psts_pkg::slot_entry_t wr_data;
  psts_pkg::slot_entry_t cur;

  // scan state
  logic [SLOT_W-1:0]           scan_idx_q;
  logic                        rd_pend_q;
  logic                        have_q;
  logic [SLOT_W-1:0]           best_slot_q;
  logic [psts_pkg::PRIO_W-1:0] best_prio_q;
  logic [psts_pkg::WORD_W-1:0] best_order_q;
  logic                        cand;
  logic                        better;
  logic                        cmp_en;

  // output register
  logic                          out_valid_q;
  logic                          res_found_q;
  logic [psts_pkg::SLOT_FW-1:0]  res_slot_q;
  logic [psts_pkg::STATUS_W-1:0] res_status_q;
  logic [psts_pkg::WORD_W-1:0]   res_order_q;
  logic                          out_free;

  // update path
  logic                          take;
  logic                          arg_neg;
  logic [psts_pkg::WORD_W-1:0]   wake_tick;
  logic                          accept;
  logic                          in_oor;
  logic                          op_done;
  logic                          pick_done;

  assign accept   = in_i.valid && in_i.ready;
  assign in_oor   = 32'(in_i.task_slot) >= 32'(TASK_SLOTS);
  assign out_free = !out_valid_q || out_o.ready;
  assign op_done  = (state_q == S_OP) && out_free;
  assign pick_done = (state_q == S_DONE) && out_free;

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.found         = res_found_q;
  assign out_o.result_slot   = res_slot_q;
  assign out_o.result_status = res_status_q;
  assign out_o.result_order  = res_order_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_i.action == psts_pkg::ACT_PICK) ? S_SCAN : S_OP;
        end
      end
      S_OP:   if (out_free) state_d = S_IDLE;
      S_SCAN: if (scan_idx_q == LAST_SLOT) state_d = S_LAST;
      S_LAST: state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // one read port: addressed slot on accept, walking index while scanning
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = SLOT_W'(in_i.task_slot);
    if (accept && !in_oor && in_i.action != psts_pkg::ACT_PICK) begin
      rd_en = 1'b1;
    end else if (state_q == S_SCAN) begin
      rd_en   = 1'b1;
      rd_addr = scan_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_hit_q  <= vld_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
    if (wr_en) begin
      mem_q[SLOT_W'(slot_q)] <= wr_data;
    end
  end

  assign cur = rd_hit_q ? rd_data_q : '0;

  // shared compare unit for the pick scan
  always_comb begin
    cand = cur.active && (cur.status == psts_pkg::ST_SLEEP) && !(now_q < cur.resume);
    better = cand && (!have_q || (cur.prio < best_prio_q) ||
                      ((cur.prio == best_prio_q) && (cur.order > best_order_q)));
    cmp_en = ((state_q == S_SCAN) && rd_pend_q) || (state_q == S_LAST);
  end

  // slot update for the non-pick actions
  assign arg_neg   = arg_q[psts_pkg::WORD_W-1];
  assign wake_tick = now_q + arg_q;

  always_comb begin
    wr_data = cur;
    take    = 1'b0;
    unique case (act_q)
      psts_pkg::ACT_REGISTER: begin
        wr_data.prio   = prio_q;
        wr_data.status = psts_pkg::ST_DEAD;
        wr_data.active = 1'b0;
        take           = 1'b1;
      end
      psts_pkg::ACT_ACTIVATE: begin
        if (cur.status == psts_pkg::ST_DEAD) begin
          wr_data.active = 1'b1;
          take           = 1'b1;
        end
        if (!arg_neg) begin
          wr_data.status = psts_pkg::ST_SLEEP;
          wr_data.resume = wake_tick;
        end else begin
          wr_data.status = psts_pkg::ST_WAIT;
        end
      end
      psts_pkg::ACT_KILL: begin
        wr_data.status = psts_pkg::ST_DEAD;
        wr_data.active = 1'b0;
        take           = cur.active;
      end
      psts_pkg::ACT_REPORT: begin
        if (!arg_neg) begin
          wr_data.resume = wake_tick;
        end else if ($signed(arg_q) == wait_code_q) begin
          wr_data.status = psts_pkg::ST_WAIT;
        end else begin
          // any other negative code kills the task
          wr_data.status = psts_pkg::ST_DEAD;
          wr_data.active = 1'b0;
          take           = cur.active;
        end
      end
      default: ;
    endcase
    if (take) begin
      wr_data.order = cnt_q;
    end
  end

  assign wr_en = op_done && !oor_q;

  // control and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_code_q <= -32'sd1;
      cnt_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      scan_idx_q  <= '0;
      rd_pend_q   <= 1'b0;
      have_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        wait_code_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        vld_q[SLOT_W'(slot_q)] <= 1'b1;
        if (take) begin
          cnt_q <= cnt_q + 32'd1;
        end
      end
      if (op_done || pick_done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        scan_idx_q <= '0;
        rd_pend_q  <= 1'b0;
        have_q     <= 1'b0;
      end else if (state_q == S_SCAN) begin
        scan_idx_q <= scan_idx_q + SLOT_W'(1);
        rd_pend_q  <= 1'b1;
      end
      if (cmp_en && better) begin
        have_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= in_i.action;
      slot_q <= in_i.task_slot;
      prio_q <= in_i.priority_req;
      arg_q  <= in_i.delay_or_return;
      now_q  <= in_i.now_tick;
      oor_q  <= in_oor;
    end
    if (cmp_en && better) begin
      best_slot_q  <= rd_idx_q;
      best_prio_q  <= cur.prio;
      best_order_q <= cur.order;
    end
    if (op_done) begin
      res_found_q  <= 1'b1;
      res_slot_q   <= slot_q;
      res_status_q <= oor_q ? psts_pkg::ST_DEAD : wr_data.status;
      res_order_q  <= oor_q ? '0 : wr_data.order;
    end else if (pick_done) begin
      res_found_q  <= have_q;
      res_slot_q   <= have_q ? psts_pkg::SLOT_FW'(best_slot_q) : '0;
      res_status_q <= have_q ? psts_pkg::ST_SLEEP : psts_pkg::ST_DEAD;
      res_order_q  <= have_q ? best_order_q : '0;
    end
  end

  // the insertion counter only moves while a slot is being updated
  a_cnt_only_on_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_OP) |=> $stable(cnt_q))
    else $error("insertion counter moved outside a slot update");

  // a pick never writes the table
  a_pick_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_LAST || state_q == S_DONE) |-> !wr_en)
    else $error("table written during a pick");

  // an empty pick reports a dead slot with order zero
  a_empty_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_found_q) |->
      (res_status_q == psts_pkg::ST_DEAD && res_order_q == '0 && res_slot_q == '0))
    else $error("empty pick result carries slot data");

  // the winner of a pick is always a sleeping slot
  a_found_sleeping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_done && have_q |=> (res_status_q == psts_pkg::ST_SLEEP && res_found_q))
    else $error("pick result is not a sleeping slot");

endmodule

/* verif/tb.sv */
module tb;

  localparam int unsigned SLOTS      = psts_pkg::TASK_SLOTS_DEF;
  localparam int unsigned IDLE_PCT   = 31;     // chance of a gap on either side
  localparam int unsigned PHASE_CMDS = 200;    // random items per wait-code setting
  localparam int unsigned HOLD_AT    = 600;    // reply count that starts the long hold
  localparam int unsigned HOLD_LEN   = 300;    // cycles the receiver holds off
  localparam int unsigned CALM_FROM  = 300;    // items with no idling on either side
  localparam int unsigned CALM_TO    = 450;
  localparam int unsigned STALL_MAX  = 4000;   // cycles with no handshake anywhere
  localparam int unsigned TAIL       = 40;     // cycles after the last reply

  // action codes the block does not know; it reports the slot untouched
  localparam logic [psts_pkg::ACTION_W-1:0] ACT_SPARE_FIRST = psts_pkg::ACT_REPORT + 1'b1;

  typedef struct packed {
    logic [psts_pkg::ACTION_W-1:0]      action;
    logic [psts_pkg::SLOT_FW-1:0]       slot;
    logic [psts_pkg::PRIO_W-1:0]        prio;
    logic signed [psts_pkg::WORD_W-1:0] arg;
    logic [psts_pkg::WORD_W-1:0]        now;
  } sched_cmd_t;

  typedef struct packed {
    logic                          found;
    logic [psts_pkg::SLOT_FW-1:0]  slot;
    logic [psts_pkg::STATUS_W-1:0] status;
    logic [psts_pkg::WORD_W-1:0]   order;
  } sched_reply_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic signed [psts_pkg::WORD_W-1:0] cfg_wdata_i;

  psts_in_if  sched_in ();
  psts_out_if sched_out ();

  priority_sleep_task_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (sched_in),
    .out_o       (sched_out)
  );

  // commands still to be offered, and replies the block still owes us
  sched_cmd_t   pending_cmds[$];
  sched_reply_t replies_due[$];

  // our own copy of the task table and the registers around it
  psts_pkg::slot_entry_t              task_rows[SLOTS];
  logic [psts_pkg::WORD_W-1:0]        next_order;
  logic signed [psts_pkg::WORD_W-1:0] wait_code;

  logic [psts_pkg::WORD_W-1:0] sim_now;       // running tick for the random part
  int unsigned                 cmds_taken;
  int unsigned                 replies_seen;
  int unsigned                 mismatches;
  int unsigned                 hold_left;
  logic                        held_once;
  int unsigned                 stall_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // prediction: one step of the scheduler on our copy of the table
  // ---------------------------------------------------------------------------

  // a slot entering a list draws the next insertion number
  function automatic void take_order(input logic [psts_pkg::SLOT_FW-1:0] s);
    task_rows[s].order = next_order;
    next_order         = next_order + 1'b1;
  endfunction

  // kill: only a slot that was in the active set gets a new insertion number
  function automatic void retire_slot(input logic [psts_pkg::SLOT_FW-1:0] s);
    task_rows[s].status = psts_pkg::ST_DEAD;
    if (task_rows[s].active) begin
      task_rows[s].active = 1'b0;
      take_order(s);
    end
  endfunction

  function automatic sched_reply_t schedule_step(input sched_cmd_t c);
    sched_reply_t                 r;
    logic [psts_pkg::SLOT_FW-1:0] best;
    logic                         have;
    have     = 1'b0;
    best     = '0;
    r.found  = 1'b1;
    r.slot   = c.slot;
    if (c.action == psts_pkg::ACT_PICK) begin
      // runnable: active, sleeping, resume tick reached (plain unsigned compare)
      for (int i = 0; i < SLOTS; i++) begin
        if (task_rows[i].active && task_rows[i].status == psts_pkg::ST_SLEEP &&
            c.now >= task_rows[i].resume) begin
          // lowest priority, then newest insertion; equal keeps the lower slot
          if (!have || task_rows[i].prio < task_rows[best].prio ||
              (task_rows[i].prio == task_rows[best].prio &&
               task_rows[i].order > task_rows[best].order)) begin
            best = psts_pkg::SLOT_FW'(i);
            have = 1'b1;
          end
        end
      end
      r.found  = have;
      r.slot   = have ? best : '0;
      r.status = have ? task_rows[best].status : psts_pkg::ST_DEAD;
      r.order  = have ? task_rows[best].order : '0;
      return r;
    end
    unique case (c.action)
      psts_pkg::ACT_REGISTER: begin
        task_rows[c.slot].prio   = c.prio;
        task_rows[c.slot].status = psts_pkg::ST_DEAD;
        task_rows[c.slot].active = 1'b0;
        take_order(c.slot);
      end
      psts_pkg::ACT_ACTIVATE: begin
        if (task_rows[c.slot].status == psts_pkg::ST_DEAD) begin
          task_rows[c.slot].active = 1'b1;
          take_order(c.slot);
        end
        // a negative delay parks the task until an explicit resume
        if (!c.arg[psts_pkg::WORD_W-1]) begin
          task_rows[c.slot].status = psts_pkg::ST_SLEEP;
          task_rows[c.slot].resume = c.now + c.arg;
        end else begin
          task_rows[c.slot].status = psts_pkg::ST_WAIT;
        end
      end
      psts_pkg::ACT_KILL: begin
        retire_slot(c.slot);
      end
      psts_pkg::ACT_REPORT: begin
        // non-negative code: new resume tick, status left as it was
        if (!c.arg[psts_pkg::WORD_W-1]) begin
          task_rows[c.slot].resume = c.now + c.arg;
        end else if (c.arg == wait_code) begin
          task_rows[c.slot].status = psts_pkg::ST_WAIT;
        end else begin
          retire_slot(c.slot);
        end
      end
      default: begin
      end
    endcase
    r.status = task_rows[c.slot].status;
    r.order  = task_rows[c.slot].order;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic calm();
    return cmds_taken >= CALM_FROM && cmds_taken < CALM_TO;
  endfunction

  task automatic queue_cmd(input logic [psts_pkg::ACTION_W-1:0] action,
                           input logic [psts_pkg::SLOT_FW-1:0] slot,
                           input logic [psts_pkg::PRIO_W-1:0] prio,
                           input logic [psts_pkg::WORD_W-1:0] arg,
                           input logic [psts_pkg::WORD_W-1:0] now);
    sched_cmd_t c;
    c.action = action;
    c.slot   = slot;
    c.prio   = prio;
    c.arg    = arg;
    c.now    = now;
    pending_cmds.push_back(c);
  endtask

  // mostly a slowly moving tick with short delays and few priorities, so that
  // picks find runnable tasks and hit priority ties; the rest is noise
  function automatic sched_cmd_t random_cmd();
    sched_cmd_t  c;
    int unsigned roll;
    sim_now = sim_now + $urandom_range(3);
    c.slot  = psts_pkg::SLOT_FW'($urandom_range(SLOTS - 1));
    c.prio  = ($urandom_range(99) < 60) ? psts_pkg::PRIO_W'($urandom_range(3)) :
                                          psts_pkg::PRIO_W'($urandom);
    c.now   = ($urandom_range(99) < 8) ? psts_pkg::WORD_W'($urandom) : sim_now;
    roll    = $urandom_range(99);
    if (roll < 12) begin
      c.action = psts_pkg::ACT_REGISTER;
    end else if (roll < 35) begin
      c.action = psts_pkg::ACT_ACTIVATE;
    end else if (roll < 43) begin
      c.action = psts_pkg::ACT_KILL;
    end else if (roll < 73) begin
      c.action = psts_pkg::ACT_PICK;
    end else begin
      c.action = psts_pkg::ACT_REPORT;
    end
    roll = $urandom_range(99);
    if (c.action == psts_pkg::ACT_ACTIVATE) begin
      if (roll < 70) begin
        c.arg = $urandom_range(15);
      end else if (roll < 85) begin
        c.arg = {1'b1, 31'($urandom)};
      end else begin
        c.arg = $urandom;
      end
    end else begin
      if (roll < 45) begin
        c.arg = $urandom_range(15);
      end else if (roll < 70) begin
        c.arg = wait_code;
      end else if (roll < 85) begin
        c.arg = {1'b1, 31'($urandom)};
      end else begin
        c.arg = $urandom;
      end
    end
    return c;
  endfunction

  // wait until the block has nothing left to do
  task automatic drain();
    while (pending_cmds.size() != 0 || sched_in.valid || replies_due.size() != 0) begin
      @(posedge clk_i);
    end
    @(posedge clk_i);
  endtask

  task automatic write_wait_code(input logic signed [psts_pkg::WORD_W-1:0] code);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    wait_code    = code;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // sender: holds an item until taken, gaps only between items
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sched_cmd_t offered;
    sched_cmd_t nxt;
    logic       busy;
    if (rst_ni) begin
      busy = sched_in.valid;
      if (sched_in.valid && sched_in.ready) begin
        offered.action = sched_in.action;
        offered.slot   = sched_in.task_slot;
        offered.prio   = sched_in.priority_req;
        offered.arg    = sched_in.delay_or_return;
        offered.now    = sched_in.now_tick;
        replies_due.push_back(schedule_step(offered));
        cmds_taken++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_cmds.size() != 0 && (calm() || $urandom_range(99) >= IDLE_PCT)) begin
          nxt                      = pending_cmds.pop_front();
          sched_in.action          <= nxt.action;
          sched_in.task_slot       <= nxt.slot;
          sched_in.priority_req    <= nxt.prio;
          sched_in.delay_or_return <= nxt.arg;
          sched_in.now_tick        <= nxt.now;
          sched_in.valid           <= 1'b1;
        end else begin
          sched_in.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: checks each reply against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [psts_pkg::WORD_W-1:0] want,
                             input logic [psts_pkg::WORD_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    sched_reply_t want;
    if (rst_ni) begin
      if (sched_out.valid && sched_out.ready) begin
        replies_seen++;
        if (replies_due.size() == 0) begin
          mismatches++;
          $display("%0t: reply with none expected, expected nothing got slot %0h order %0h",
                   $time, sched_out.result_slot, sched_out.result_order);
        end else begin
          want = replies_due.pop_front();
          check_field("found", psts_pkg::WORD_W'(want.found),
                      psts_pkg::WORD_W'(sched_out.found));
          check_field("result_slot", psts_pkg::WORD_W'(want.slot),
                      psts_pkg::WORD_W'(sched_out.result_slot));
          check_field("result_status", psts_pkg::WORD_W'(want.status),
                      psts_pkg::WORD_W'(sched_out.result_status));
          check_field("result_order", want.order, sched_out.result_order);
        end
      end
      // one long hold-off so the block fills up and backs up its input
      if (hold_left != 0) begin
        hold_left--;
        sched_out.ready <= 1'b0;
      end else if (!held_once && replies_seen >= HOLD_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_LEN;
        sched_out.ready <= 1'b0;
      end else begin
        sched_out.ready <= calm() || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sched_in.valid && sched_in.ready) || (sched_out.valid && sched_out.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_MAX) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic signed [psts_pkg::WORD_W-1:0] codes[5];
    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_wdata_i              = '0;
    sched_in.valid           = 1'b0;
    sched_in.action          = '0;
    sched_in.task_slot       = '0;
    sched_in.priority_req    = '0;
    sched_in.delay_or_return = '0;
    sched_in.now_tick        = '0;
    sched_out.ready          = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      task_rows[i] = '0;
    end
    next_order   = '0;
    wait_code    = -1;
    sim_now      = '0;
    cmds_taken   = 0;
    replies_seen = 0;
    mismatches   = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    stall_cycles = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, wait code at its reset value
    queue_cmd(psts_pkg::ACT_PICK, 0, 0, 0, 0);                       // empty table
    queue_cmd(psts_pkg::ACT_REGISTER, 0, 8'hFF, 0, 0);
    queue_cmd(psts_pkg::ACT_REGISTER, 15, 8'h00, 0, 0);
    queue_cmd(psts_pkg::ACT_ACTIVATE, 0, 0, 0, 0);                   // due at once
    queue_cmd(psts_pkg::ACT_ACTIVATE, 15, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF); // tick wraps
    queue_cmd(psts_pkg::ACT_PICK, 0, 0, 0, 0);                       // wrapped slot not due
    queue_cmd(psts_pkg::ACT_PICK, 0, 0, 0, 32'hFFFF_FFFF);
    queue_cmd(psts_pkg::ACT_REGISTER, 3, 8'h00, 0, 0);
    queue_cmd(psts_pkg::ACT_ACTIVATE, 3, 0, 5, 10);
    queue_cmd(psts_pkg::ACT_PICK, 0, 0, 0, 14);                      // one tick early
    queue_cmd(psts_pkg::ACT_PICK, 0, 0, 0, 15);                      // exactly due
    queue_cmd(psts_pkg::ACT_REGISTER, 4, 8'h00, 0, 0);
    queue_cmd(psts_pkg::ACT_ACTIVATE, 4, 0, 0, 15);
    queue_cmd(psts_pkg::ACT_PICK, 0, 0, 0, 20);                      // tie, newer wins
    queue_cmd(psts_pkg::ACT_ACTIVATE, 4, 0, 32'h8000_0000, 20);      // park, no new order
    queue_cmd(psts_pkg::ACT_REPORT, 3, 0, 32'h7FFF_FFFF, 0);
    queue_cmd(psts_pkg::ACT_REPORT, 3, 0, 32'hFFFF_FFFF, 0);         // wait for resume
    queue_cmd(psts_pkg::ACT_REPORT, 0, 0, 32'h8000_0000, 0);         // other negative kills
    queue_cmd(psts_pkg::ACT_KILL, 15, 0, 0, 0);
    queue_cmd(psts_pkg::ACT_KILL, 15, 0, 0, 0);                      // already out of the set
    queue_cmd(psts_pkg::ACT_KILL, 7, 0, 0, 0);                       // never registered
    for (int a = ACT_SPARE_FIRST; a < 2 ** psts_pkg::ACTION_W; a++) begin
      queue_cmd(psts_pkg::ACTION_W'(a), 4, 8'hA5, 32'h1234_5678, 0);
    end
    queue_cmd(psts_pkg::ACT_REPORT, 7, 0, 32'hFFFF_FFFF, 0);         // waiting, not active
    queue_cmd(psts_pkg::ACT_ACTIVATE, 7, 0, 0, 0);                   // sleeping, never picked
    queue_cmd(psts_pkg::ACT_PICK, 0, 0, 0, 32'hFFFF_FFFF);
    drain();

    // random part, one wait-code setting per phase, extremes included
    codes[0] = -1;
    codes[1] = 32'sh8000_0000;
    codes[2] = {1'b1, 31'($urandom)};
    codes[3] = -2;
    codes[4] = -1;
    foreach (codes[p]) begin
      write_wait_code(codes[p]);
      for (int n = 0; n < PHASE_CMDS; n++) begin
        pending_cmds.push_back(random_cmd());
      end
      drain();
    end

    repeat (TAIL) @(posedge clk_i);
    if (replies_due.size() != 0) begin
      mismatches++;
      $display("%0t: replies outstanding, expected 0 got %0d", $time, replies_due.size());
    end
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
